// ===== hw/rtl/cio_pkg.sv =====
// package for the console i/o timer and pad port
// holds request/response types, action codes and decode constants; no dependencies
`timescale 1ns / 1ps

package cio_pkg;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [7:0]  IO_BANK    = 8'hff;
    localparam logic [12:0] DEV_MASK   = 13'h1c00;
    localparam logic [12:0] DEV_TIMER  = 13'h0c00;
    localparam logic [12:0] DEV_PAD    = 13'h1000;
    localparam logic [7:0]  COUNT_MASK = 8'h7f;
    localparam logic [7:0]  BYTE_MASK  = 8'hff;
    localparam logic [7:0]  NIB_MASK   = 8'h0f;
    localparam logic [7:0]  CTRY_BIT   = 8'h40;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  bank;
        logic [12:0] page_offset;
        logic [7:0]  write_data;
        logic [7:0]  buttons;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       served;
        logic       timer_irq;
    } t_rsp;

endpackage

// ===== hw/rtl/cio_if.sv =====
// valid/ready channel interfaces for requests and responses
// standalone, no package dependency
`timescale 1ns / 1ps

interface cio_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  bank;
    logic [12:0] page_offset;
    logic [7:0]  write_data;
    logic [7:0]  buttons;

    modport source (output valid, action, bank, page_offset, write_data, buttons,
                    input ready);
    modport sink   (input valid, action, bank, page_offset, write_data, buttons,
                    output ready);
endinterface

interface cio_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       served;
    logic       timer_irq;

    modport source (output valid, read_data, served, timer_irq, input ready);
    modport sink   (input valid, read_data, served, timer_irq, output ready);
endinterface

// ===== hw/rtl/console_io_timer_and_pad_port.sv =====
// top level: input request register, core decode, response register
// a request is registered at the input, and its decoded response again at the output
// throughput: one request per cycle; both stages advance together unless the response stalls
// reset: synchronous active-low i_rst_n empties both stages and clears timer and pad state,
// country flag resets to 1; depends on cio_pkg, cio_if, cio_core
`timescale 1ns / 1ps

module console_io_timer_and_pad_port (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cio_req_if.sink  i_req,
    cio_rsp_if.source o_rsp,
    input  logic     i_cfg_we,
    input  logic     i_cfg_data
);
    import cio_pkg::*;

    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    t_rsp core_rsp;
    logic advance;
    logic in_take;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign in_take     = i_req.valid && i_req.ready;
    assign i_req.ready = !r_in_valid || advance;

    cio_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_req      (r_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action      <= i_req.action;
            r_in.bank        <= i_req.bank;
            r_in.page_offset <= i_req.page_offset;
            r_in.write_data  <= i_req.write_data;
            r_in.buttons     <= i_req.buttons;
        end
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.read_data = r_out.read_data;
    assign o_rsp.served    = r_out.served;
    assign o_rsp.timer_irq = r_out.timer_irq;

    a_irq_not_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.served && r_out.timer_irq))
        else $error("response has both served and timer_irq");

    a_data_needs_served: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.read_data != 8'h00) |-> r_out.served)
        else $error("nonzero read_data on unserved request");

    a_take_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted request lost from input stage");

    a_stall_keeps_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> r_out_valid)
        else $error("stalled response dropped");

endmodule

// ===== hw/rtl/cio_core.sv =====
// timer and pad port state with the single-pass decode of one request
// depends on cio_pkg
`timescale 1ns / 1ps

module cio_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  cio_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    output cio_pkg::t_rsp o_rsp
);
    import cio_pkg::*;

    logic [7:0] r_timer_preload, n_timer_preload;
    logic [6:0] r_timer_count, n_timer_count;
    logic [7:0] r_timer_control, n_timer_control;
    logic       r_pad_sel, n_pad_sel;
    logic       r_country;
    logic       io_hit;
    logic [12:0] dev;
    logic [3:0] nib;
    logic [7:0] pad_raw;

    assign io_hit  = (i_req.bank == IO_BANK);
    assign dev     = i_req.page_offset & DEV_MASK;
    assign nib     = r_pad_sel ? i_req.buttons[7:4] : (i_req.buttons[3:0] & NIB_MASK[3:0]);
    assign pad_raw = {4'b0000, nib} | (r_country ? CTRY_BIT : 8'h00);

    always_comb begin
        n_timer_preload = r_timer_preload;
        n_timer_count   = r_timer_count;
        n_timer_control = r_timer_control;
        n_pad_sel       = r_pad_sel;
        o_rsp           = '0;
        unique case (i_req.action)
            ACT_TICK: begin
                if (r_timer_control[0]) begin
                    if (r_timer_count == 7'd0) begin
                        n_timer_count   = r_timer_preload[6:0] & COUNT_MASK[6:0];
                        o_rsp.timer_irq = 1'b1;
                    end else begin
                        n_timer_count = r_timer_count - 7'd1;
                    end
                end
            end
            ACT_READ, ACT_WRITE: begin
                if (io_hit && dev == DEV_TIMER) begin
                    o_rsp.served = 1'b1;
                    if (i_req.action == ACT_READ) begin
                        o_rsp.read_data = i_req.page_offset[0] ? r_timer_control
                                                               : {1'b0, r_timer_count};
                    end else if (i_req.page_offset[0]) begin
                        if (!r_timer_control[0] && i_req.write_data[0]) begin
                            n_timer_count = r_timer_preload[6:0] & COUNT_MASK[6:0];
                        end
                        n_timer_control = i_req.write_data;
                    end else begin
                        n_timer_preload = i_req.write_data;
                    end
                end else if (io_hit && dev == DEV_PAD) begin
                    o_rsp.served = 1'b1;
                    if (i_req.action == ACT_READ) begin
                        o_rsp.read_data = pad_raw ^ BYTE_MASK;
                    end else begin
                        n_pad_sel = i_req.write_data[0];
                    end
                end
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_preload <= '0;
            r_timer_count   <= '0;
            r_timer_control <= '0;
            r_pad_sel       <= 1'b0;
            r_country       <= 1'b1;
        end else begin
            if (i_step) begin
                r_timer_preload <= n_timer_preload;
                r_timer_count   <= n_timer_count;
                r_timer_control <= n_timer_control;
                r_pad_sel       <= n_pad_sel;
            end
            if (i_cfg_we) begin
                r_country <= i_cfg_data;
            end
        end
    end

endmodule
